/* design/jts_pkg.sv */
// Shared types, character codes and classification functions for the JSON token scanner.
package jts_pkg;

   localparam int POSITION_BITS_DEFAULT = 32;
   localparam longint unsigned LENGTH_LIMIT_DEFAULT = 64'd65535;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [3:0] KIND_END       = 4'd0;
   localparam logic [3:0] KIND_LBRACE    = 4'd1;
   localparam logic [3:0] KIND_RBRACE    = 4'd2;
   localparam logic [3:0] KIND_LBRACKET  = 4'd3;
   localparam logic [3:0] KIND_RBRACKET  = 4'd4;
   localparam logic [3:0] KIND_COMMA     = 4'd5;
   localparam logic [3:0] KIND_COLON     = 4'd6;
   localparam logic [3:0] KIND_NUMBER    = 4'd7;
   localparam logic [3:0] KIND_STRING    = 4'd8;
   localparam logic [3:0] KIND_IDENT     = 4'd9;
   localparam logic [3:0] KIND_NULL      = 4'd10;
   localparam logic [3:0] KIND_TRUE      = 4'd11;
   localparam logic [3:0] KIND_FALSE     = 4'd12;
   localparam logic [3:0] KIND_NEWLINE   = 4'd13;
   localparam logic [3:0] KIND_UNTERM    = 4'd14;

   localparam logic [7:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [7:0] CHAR_COMMA     = 8'h2C;
   localparam logic [7:0] CHAR_COLON     = 8'h3A;
   localparam logic [7:0] CHAR_PLUS      = 8'h2B;
   localparam logic [7:0] CHAR_MINUS     = 8'h2D;
   localparam logic [7:0] CHAR_DOT       = 8'h2E;

   localparam logic [2:0] CAND_NULL  = 3'b001;
   localparam logic [2:0] CAND_FALSE = 3'b010;
   localparam logic [2:0] CAND_TRUE  = 3'b100;
   localparam logic [2:0] CAND_ALL   = 3'b111;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]  token_kind;
      logic [31:0] token_start;
      logic [15:0] token_length;
      logic [31:0] line_number;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    tok1;
      rsp_type    tok0;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   function automatic logic is_digit(logic [7:0] b);
      return (b >= "0") && (b <= "9");
   endfunction

   function automatic logic is_alpha(logic [7:0] b);
      return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
   endfunction

   function automatic logic is_num_char(logic [7:0] b);
      return is_digit(b) || ((b >= "a") && (b <= "f")) || ((b >= "A") && (b <= "F")) ||
             (b == CHAR_DOT) || (b == CHAR_PLUS) || (b == CHAR_MINUS);
   endfunction

   function automatic logic is_num_start(logic [7:0] b);
      return is_digit(b) || (b == CHAR_PLUS) || (b == CHAR_MINUS);
   endfunction

   function automatic logic [3:0] punct_kind(logic [7:0] b);
      logic [3:0] k;
      k = KIND_END;
      if (b == CHAR_LBRACE) k = KIND_LBRACE;
      if (b == CHAR_RBRACE) k = KIND_RBRACE;
      if (b == CHAR_LBRACKET) k = KIND_LBRACKET;
      if (b == CHAR_RBRACKET) k = KIND_RBRACKET;
      if (b == CHAR_COMMA) k = KIND_COMMA;
      if (b == CHAR_COLON) k = KIND_COLON;
      return k;
   endfunction

   // Keywords that still match when byte b sits at index idx of the word.
   function automatic logic [2:0] keyword_keep(logic [2:0] idx, logic [7:0] b);
      logic [2:0] keep;
      keep = 3'b000;
      unique case (idx)
         3'd0: begin
            if (b == "n") keep = keep | CAND_NULL;
            if (b == "f") keep = keep | CAND_FALSE;
            if (b == "t") keep = keep | CAND_TRUE;
         end
         3'd1: begin
            if (b == "u") keep = keep | CAND_NULL;
            if (b == "a") keep = keep | CAND_FALSE;
            if (b == "r") keep = keep | CAND_TRUE;
         end
         3'd2: begin
            if (b == "l") keep = keep | CAND_NULL | CAND_FALSE;
            if (b == "u") keep = keep | CAND_TRUE;
         end
         3'd3: begin
            if (b == "l") keep = keep | CAND_NULL;
            if (b == "s") keep = keep | CAND_FALSE;
            if (b == "e") keep = keep | CAND_TRUE;
         end
         3'd4: begin
            if (b == "e") keep = keep | CAND_FALSE;
         end
         default: keep = 3'b000;
      endcase
      return keep;
   endfunction

endpackage

/* design/jts_front.sv */
// Scanner front end: accepts text bytes, tracks lexer state and forms up to two tokens per byte.
module jts_front import jts_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
   parameter longint unsigned LENGTH_LIMIT = LENGTH_LIMIT_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      accept,
   input  req_type   req_data,
   output entry_type entry,
   output logic      entry_push
);

   localparam int SB = (POSITION_BITS < 64) ? POSITION_BITS + 1 : 64;
   localparam int LB = $clog2(LENGTH_LIMIT + 64'd1);
   localparam int SW = (SB > 32) ? SB : 33;
   localparam int LW = (LB > 16) ? LB : 17;
   localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
   localparam logic [LB-1:0] LEN_MAX = LB'(LENGTH_LIMIT);

   typedef enum logic [3:0] {
      MODE_IDLE   = 4'b0001,
      MODE_NUMBER = 4'b0010,
      MODE_WORD   = 4'b0100,
      MODE_STRING = 4'b1000
   } mode_type;

   mode_type                 mode_ff, mode_in;
   logic                     esc_ff, esc_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [SB-1:0]            start_ff, start_in;
   logic [LB-1:0]            len_ff, len_in;
   logic [31:0]              line_ff, line_in;
   logic [2:0]               cand_ff, cand_in;
   logic                     idle_scan;
   logic [7:0]               b;
   entry_type                ent;

   function automatic logic [LB-1:0] len_inc(logic [LB-1:0] v);
      return (v >= LEN_MAX) ? LEN_MAX : v + LB'(1);
   endfunction

   function automatic logic [2:0] len_index(logic [LB-1:0] v);
      return (v < LB'(5)) ? v[2:0] : 3'd7;
   endfunction

   function automatic logic [3:0] word_kind(logic [2:0] cand, logic [LB-1:0] len);
      logic [3:0] k;
      k = KIND_IDENT;
      if ((cand[2] == 1'b1) && (len == LB'(4))) k = KIND_TRUE;
      if ((cand[1] == 1'b1) && (len == LB'(5))) k = KIND_FALSE;
      if ((cand[0] == 1'b1) && (len == LB'(4))) k = KIND_NULL;
      return k;
   endfunction

   function automatic rsp_type make_tok(logic [3:0] kind, logic [SB-1:0] start,
                                        logic [LB-1:0] len, logic [31:0] line);
      rsp_type    t;
      logic [SW-1:0] sx;
      logic [LW-1:0] lx;
      sx = SW'(start);
      lx = LW'(len);
      t.token_kind   = kind;
      t.token_start  = (sx > SW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : sx[31:0];
      t.token_length = (lx > LW'(16'hFFFF)) ? 16'hFFFF : lx[15:0];
      t.line_number  = line;
      t.last_of_run  = 1'b0;
      return t;
   endfunction

   function automatic entry_type add_tok(entry_type e, rsp_type t);
      entry_type r;
      r = e;
      if (e.count == 2'd0) r.tok0 = t;
      if (e.count == 2'd1) r.tok1 = t;
      if (e.count != 2'd2) r.count = e.count + 2'd1;
      return r;
   endfunction

   assign b = req_data.text_byte;

   always_comb begin
      mode_in   = mode_ff;
      esc_in    = esc_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      len_in    = len_ff;
      line_in   = line_ff;
      cand_in   = cand_ff;
      idle_scan = 1'b0;
      ent       = '0;

      unique case (mode_ff)
         MODE_NUMBER: begin
            if (is_num_char(b)) begin
               len_in = len_inc(len_ff);
            end else begin
               ent = add_tok(ent, make_tok(KIND_NUMBER, start_ff, len_ff, line_ff));
               mode_in = MODE_IDLE;
               idle_scan = 1'b1;
            end
         end
         MODE_WORD: begin
            if (is_alpha(b)) begin
               cand_in = cand_ff & keyword_keep(len_index(len_ff), b);
               len_in = len_inc(len_ff);
            end else begin
               ent = add_tok(ent, make_tok(word_kind(cand_ff, len_ff), start_ff, len_ff,
                                           line_ff));
               mode_in = MODE_IDLE;
               idle_scan = 1'b1;
            end
         end
         MODE_STRING: begin
            if (b == CHAR_NEWLINE) begin
               ent = add_tok(ent, make_tok(KIND_NEWLINE, start_ff, len_ff, line_ff));
               if (line_ff != 32'hFFFF_FFFF) line_in = line_ff + 32'd1;
               mode_in = MODE_IDLE;
               esc_in = 1'b0;
            end else if ((b == CHAR_QUOTE) && !esc_ff) begin
               ent = add_tok(ent, make_tok(KIND_STRING, start_ff, len_ff, line_ff));
               mode_in = MODE_IDLE;
            end else begin
               esc_in = (b == CHAR_BACKSLASH) ? !esc_ff : 1'b0;
               len_in = len_inc(len_ff);
            end
         end
         MODE_IDLE: begin
            idle_scan = 1'b1;
         end
         default: begin
            mode_in = MODE_IDLE;
            idle_scan = 1'b1;
         end
      endcase

      if (idle_scan) begin
         priority if (b == CHAR_NEWLINE) begin
            if (line_ff != 32'hFFFF_FFFF) line_in = line_ff + 32'd1;
         end else if (punct_kind(b) != KIND_END) begin
            ent = add_tok(ent, make_tok(punct_kind(b), SB'(pos_ff), LB'(1), line_ff));
         end else if (b == CHAR_QUOTE) begin
            mode_in = MODE_STRING;
            esc_in = 1'b0;
            start_in = SB'(pos_ff) + SB'(1);
            len_in = '0;
         end else if (is_num_start(b)) begin
            mode_in = MODE_NUMBER;
            start_in = SB'(pos_ff);
            len_in = LB'(1);
         end else if (is_alpha(b)) begin
            mode_in = MODE_WORD;
            start_in = SB'(pos_ff);
            len_in = LB'(1);
            cand_in = CAND_ALL & keyword_keep(3'd0, b);
         end else begin
            mode_in = mode_in;
         end
      end

      if (req_data.final_byte) begin
         unique case (mode_in)
            MODE_NUMBER: ent = add_tok(ent, make_tok(KIND_NUMBER, start_in, len_in, line_in));
            MODE_WORD: ent = add_tok(ent, make_tok(word_kind(cand_in, len_in), start_in,
                                                   len_in, line_in));
            MODE_STRING: ent = add_tok(ent, make_tok(KIND_UNTERM, start_in, len_in, line_in));
            default: ent = ent;
         endcase
         ent = add_tok(ent, make_tok(KIND_END,
                                     SB'((pos_ff == POS_MAX) ? pos_ff : pos_ff + 1'b1),
                                     '0, line_in));
         mode_in  = MODE_IDLE;
         esc_in   = 1'b0;
         pos_in   = '0;
         start_in = '0;
         len_in   = '0;
         line_in  = 32'd1;
         cand_in  = CAND_ALL;
      end else if (pos_ff != POS_MAX) begin
         pos_in = pos_ff + 1'b1;
      end

      if (ent.count == 2'd1) begin
         ent.tok0.last_of_run = 1'b1;
      end else if (ent.count == 2'd2) begin
         ent.tok1.last_of_run = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         esc_ff   <= 1'b0;
         pos_ff   <= '0;
         start_ff <= '0;
         len_ff   <= '0;
         line_ff  <= 32'd1;
         cand_ff  <= CAND_ALL;
      end else if (accept) begin
         mode_ff  <= mode_in;
         esc_ff   <= esc_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         len_ff   <= len_in;
         line_ff  <= line_in;
         cand_ff  <= cand_in;
      end
   end

   assign entry      = ent;
   assign entry_push = accept && (ent.count != 2'd0);

endmodule

/* design/jts_queue.sv */
// Short register queue that holds token groups between the scanner and the output stage.
module jts_queue import jts_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  entry_type        push_entry,
   input  logic             pop,
   output entry_type        head,
   output queue_status_type status
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   entry_type       slots_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, wr_in;
   logic [PW-1:0]   rd_ff, rd_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push;
   logic            do_pop;

   assign do_push = push && (count_ff != CW'(QUEUE_DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (do_push) wr_in = (wr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      if (do_pop) rd_in = (rd_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      if (do_push && !do_pop) count_in = count_ff + CW'(1);
      if (do_pop && !do_push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slots_ff[wr_ff] <= push_entry;
   end

   assign head         = slots_ff[rd_ff];
   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == CW'(QUEUE_DEPTH));

endmodule

/* design/jts_back.sv */
// Output stage: takes token groups from the queue and presents them one item at a time.
module jts_back import jts_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  entry_type        head,
   input  queue_status_type status,
   output logic             dequeue,
   input  logic             pop,
   output logic             empty,
   output rsp_type          rsp_data
);

   entry_type cur_ff, cur_in;
   logic      valid_ff, valid_in;
   logic      idx_ff, idx_in;
   logic      load;

   always_comb begin
      cur_in   = cur_ff;
      valid_in = valid_ff;
      idx_in   = idx_ff;
      dequeue  = 1'b0;
      load     = !valid_ff;
      if (valid_ff && pop) begin
         if (!idx_ff && (cur_ff.count == 2'd2)) begin
            idx_in = 1'b1;
         end else begin
            load = 1'b1;
         end
      end
      if (load) begin
         idx_in   = 1'b0;
         valid_in = !status.empty;
         dequeue  = !status.empty;
         if (!status.empty) cur_in = head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   assign empty    = !valid_ff;
   assign rsp_data = idx_ff ? cur_ff.tok1 : cur_ff.tok0;

endmodule

/* design/json_token_scanner.sv */
// Streaming JSON lexer: one text byte per item in, one token per item out.
// A token is registered in the group queue and then in the output stage before it reaches the result ports.
// Throughput: one byte per cycle; a byte that gives two tokens presents them one after the other,
// and the input stalls only when the group queue between scanner and output stage is full.
// Reset is synchronous and active high; it empties the queue and output stage and returns
// the scanner to the idle mode at offset zero on line one.
module json_token_scanner import jts_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
   parameter longint unsigned LENGTH_LIMIT = LENGTH_LIMIT_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   input  logic    pop,
   output logic    empty,
   output rsp_type rsp_data
);

   queue_status_type status;
   entry_type        entry;
   entry_type        head;
   logic             entry_push;
   logic             dequeue;

   assign full = status.full;

   jts_front #(
      .POSITION_BITS (POSITION_BITS),
      .LENGTH_LIMIT  (LENGTH_LIMIT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (push && !status.full),
      .req_data   (req_data),
      .entry      (entry),
      .entry_push (entry_push)
   );

   jts_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (entry_push),
      .push_entry (entry),
      .pop        (dequeue),
      .head       (head),
      .status     (status)
   );

   jts_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .status   (status),
      .dequeue  (dequeue),
      .pop      (pop),
      .empty    (empty),
      .rsp_data (rsp_data)
   );

endmodule

/* design/jts_checker.sv */
// Port-level checker for the JSON token scanner and its bind to the top level.
module jts_checker import jts_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    push,
   input logic    full,
   input req_type req_data,
   input logic    pop,
   input logic    empty,
   input rsp_type rsp_data
);

   a_empty_after_reset: assert property (@(posedge clock) reset |=> empty)
      else $error("Output is not empty after reset.");

   a_hold_when_stalled: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("Waiting item changed before it was taken.");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.token_kind <= KIND_UNTERM))
      else $error("Token kind out of range.");

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.line_number != 32'd0))
      else $error("Line number is zero.");

   a_end_token: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_data.token_kind == KIND_END)) |->
      ((rsp_data.token_length == 16'd0) && rsp_data.last_of_run))
      else $error("End token has a length or is not last of its run.");

endmodule

bind json_token_scanner jts_checker u_checker (.*);
